// File: rtl/core/pcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

  localparam int CHAR_SLOTS       = 128;
  localparam int COLUMNS_PER_CHAR = 6;

  localparam int GLYPH_W     = 48;
  localparam int STORED_COLS = GLYPH_W / 8;
  localparam int CHAR_AW     = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1;
  localparam int COUNT_W     = $clog2(CHAR_SLOTS + 1);
  localparam int COL_W       = (COLUMNS_PER_CHAR > 1) ? $clog2(COLUMNS_PER_CHAR) : 1;

  localparam logic [7:0] TICK_INTERVAL_RST = 8'd183;
  localparam logic [7:0] OVF_PER_COL_RST   = 8'd254;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_APPEND  = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  // period/360 + 1 as (period>>3)/45 via reciprocal multiply.
  // 11651 = ceil(2^19/45); exact for all 13-bit dividends.
  localparam logic [13:0] RECIP_45 = 14'd11651;
  localparam int          RECIP_SH = 19;

  function automatic logic [7:0] period_to_interval(input logic [15:0] period);
    logic [26:0] prod;
    logic [7:0]  quot;
    prod = {14'd0, period[15:3]} * {13'd0, RECIP_45};
    quot = prod[RECIP_SH +: 8];
    return quot + 8'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pov_column_scanner_top.sv
// A tick that completes a column passes the store read register, then the output register.
// Throughput: one transaction per cycle unless output back-pressure stalls the read stage;
//   the single-port-read text store is read once per finished column, appends write it,
//   and the two never touch the same entry.
// Reset: counters, position and handshake state clear; tick interval 183, register 254.
//   The text store has no reset; with an empty store the column read is masked to zero.
`timescale 1ns / 1ps
`default_nettype none

module pov_column_scanner_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] period_i,
  input  wire logic [47:0] glyph_columns_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       low_pins_o,
  output logic [5:0]       high_pins_o,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam int AW = pcs_pkg::CHAR_AW;
  localparam int CW = pcs_pkg::COUNT_W;
  localparam int LW = pcs_pkg::COL_W;

  logic [7:0]    ovf_per_col_q;
  logic [CW-1:0] char_count_q, char_count_d;
  logic [AW-1:0] char_pos_q, char_pos_d;
  logic [LW-1:0] column_pos_q, column_pos_d;
  logic [7:0]    tick_interval_q, tick_interval_d;
  logic [7:0]    tick_count_q, tick_count_d;
  logic [7:0]    overflow_count_q, overflow_count_d;

  logic          s1_valid_q;
  logic          s1_zero_q;
  logic [LW-1:0] s1_col_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;

  logic          accept;
  logic          out_free;
  logic          is_tick, is_capture, is_append;
  logic          tick_wrap;
  logic          emit;
  logic          store_full;
  logic [8:0]    ovf_next;
  logic [CW-1:0] char_pos_inc;
  logic [pcs_pkg::GLYPH_W-1:0] rdata;
  logic [pcs_pkg::GLYPH_W-1:0] glyph_shift;
  logic [7:0]    col_byte;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign is_tick    = (mode_i == pcs_pkg::MODE_TICK);
  assign is_capture = (mode_i == pcs_pkg::MODE_CAPTURE);
  assign is_append  = (mode_i == pcs_pkg::MODE_APPEND);

  assign tick_wrap  = (tick_count_q >= tick_interval_q);
  assign ovf_next   = {1'b0, overflow_count_q} + 9'd1;
  assign emit       = accept && is_tick && tick_wrap && (ovf_next >= {1'b0, ovf_per_col_q});
  assign store_full = (char_count_q >= CW'(pcs_pkg::CHAR_SLOTS));
  assign char_pos_inc = CW'(char_pos_q) + CW'(1);

  always_comb begin
    char_count_d     = char_count_q;
    char_pos_d       = char_pos_q;
    column_pos_d     = column_pos_q;
    tick_interval_d  = tick_interval_q;
    tick_count_d     = tick_count_q;
    overflow_count_d = overflow_count_q;
    if (accept) begin
      if (is_capture) begin
        tick_interval_d = pcs_pkg::period_to_interval(period_i);
      end
      if (is_append && !store_full) begin
        char_count_d = char_count_q + CW'(1);
      end
      if (is_tick) begin
        if (!tick_wrap) begin
          tick_count_d = tick_count_q + 8'd1;
        end else begin
          tick_count_d = 8'd0;
          if (!emit) begin
            overflow_count_d = ovf_next[7:0];
          end else begin
            overflow_count_d = 8'd0;
            if (32'(column_pos_q) + 1 >= pcs_pkg::COLUMNS_PER_CHAR) begin
              column_pos_d = '0;
              if (char_pos_inc >= char_count_q ||
                  char_pos_inc >= CW'(pcs_pkg::CHAR_SLOTS)) begin
                char_pos_d = '0;
              end else begin
                char_pos_d = char_pos_inc[AW-1:0];
              end
            end else begin
              column_pos_d = column_pos_q + LW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_per_col_q    <= pcs_pkg::OVF_PER_COL_RST;
      char_count_q     <= '0;
      char_pos_q       <= '0;
      column_pos_q     <= '0;
      tick_interval_q  <= pcs_pkg::TICK_INTERVAL_RST;
      tick_count_q     <= '0;
      overflow_count_q <= '0;
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ovf_per_col_q <= cfg_wdata_i;
      end
      char_count_q     <= char_count_d;
      char_pos_q       <= char_pos_d;
      column_pos_q     <= column_pos_d;
      tick_interval_q  <= tick_interval_d;
      tick_count_q     <= tick_count_d;
      overflow_count_q <= overflow_count_d;
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (emit) begin
        s1_valid_q <= 1'b1;
      end else if (out_free) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // payload side of the read stage and the output register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_zero_q <= (char_count_q == '0);
      s1_col_q  <= column_pos_q;
    end
    if (out_free && s1_valid_q) begin
      out_byte_q <= col_byte;
    end
  end

  pcs_ram #(
    .WIDTH (pcs_pkg::GLYPH_W),
    .DEPTH (pcs_pkg::CHAR_SLOTS)
  ) u_text_store (
    .clk_i   (clk_i),
    .we_i    (accept && is_append && !store_full),
    .waddr_i (char_count_q[AW-1:0]),
    .wdata_i (glyph_columns_i),
    .re_i    (emit),
    .raddr_i (char_pos_q),
    .rdata_o (rdata)
  );

  // read data holds while the stage stalls: no read is issued without an accept
  assign glyph_shift = rdata >> {s1_col_q, 3'b000};
  assign col_byte = (s1_zero_q || 32'(s1_col_q) >= pcs_pkg::STORED_COLS) ?
                    8'd0 : glyph_shift[7:0];

  assign out_valid_o = out_valid_q;
  assign low_pins_o  = out_byte_q[1:0];
  assign high_pins_o = out_byte_q[7:2];

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while read stage is stalled");

  a_emit_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> s1_valid_q)
    else $error("finished column lost in read stage");

  a_pos_in_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_count_q != '0) |-> (CW'(char_pos_q) < char_count_q))
    else $error("character position beyond stored count");

  a_empty_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_count_q == '0) |-> (char_pos_q == '0))
    else $error("nonzero position with empty store");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_count_q <= CW'(pcs_pkg::CHAR_SLOTS))
    else $error("stored count overflow");

endmodule

`default_nettype wire
